/* src/assert_macros.svh */
// Assertion macros used by the checker module.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDME_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gdme_pkg.sv */
package gdme_pkg;

  // Reset values of the configuration registers.
  localparam logic [11:0] THRESH_RESET     = 12'd30;
  localparam logic [5:0]  START_XY_RESET   = 6'd32;
  localparam logic [1:0]  START_HEAD_RESET = 2'd0;

  typedef enum logic [1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_START_X    = 2'd1,
    CFG_START_Y    = 2'd2,
    CFG_START_HEAD = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_ADVANCE = 2'd0,
    ACT_BACK    = 2'd1,
    ACT_HALT    = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    TURN_NONE   = 2'd0,
    TURN_RIGHT  = 2'd1,
    TURN_AROUND = 2'd2,
    TURN_LEFT   = 2'd3
  } turn_e;

  // Headings: north is +y, east is +x.
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_FRONT,
    ST_DECIDE,
    ST_POP
  } gdme_state_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic mark;
    logic front;
    logic decide;
    logic pop;
    logic report;
  } gdme_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic halted;
    logic pop_needed;
  } gdme_status_t;

endpackage

/* src/grid_dfs_maze_explorer.sv */
// Depth-first maze explorer on a square grid of cells.
// Input: a command word (dist_left_i, dist_right_i, dist_front_i) is taken at a rising
// edge with start high and busy low. Configuration: cfg_valid_i/cfg_ready_o carry a
// register index and data; ready is always high, and writes are meant for idle periods.
// Output: one result word per command, shown for exactly one cycle with done_o high.
// The receiver cannot stall the block, so the result must be taken in that cycle.
// Sequence: an advance or a halt is shown after the mark, front and decide states,
// a backtrack after the pop state as well; a command given after the block has
// halted is answered in the next cycle. Busy drops in the cycle that shows the
// result, so a command can be taken then but not mid-step. The step is paced by the
// visited map: the current cell is marked while left and right are read, the front
// neighbor is read on the next cycle, and a backtrack costs one more stack read.
// Reset: the position is loaded from the start registers on the first command after
// reset. Reset also starts a clearing sweep of all 2**(2*ceil(log2(GRID_SIZE))) cells
// of the visited map (4096 at the default size), one cell per cycle; busy stays high
// during the sweep while configuration writes are still taken.
module grid_dfs_maze_explorer import gdme_pkg::*; #(
  parameter int GRID_SIZE   = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] dist_left_i,
  input  logic [11:0] dist_right_i,
  input  logic [11:0] dist_front_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  action_o,
  output logic [1:0]  turn_o,
  output logic [5:0]  new_x_o,
  output logic [5:0]  new_y_o,
  output logic [1:0]  new_heading_o,
  output logic [12:0] depth_o
);

  gdme_cmd_t    cmd;
  gdme_status_t status;

  // The configuration registers never hold a write off.
  assign cfg_ready_o = 1'b1;

  // The controller sequences mark, front read, decision and optional pop.
  gdme_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the registers, the visited map and the return stack.
  gdme_datapath #(
    .GRID_SIZE   (GRID_SIZE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .dist_left_i   (dist_left_i),
    .dist_right_i  (dist_right_i),
    .dist_front_i  (dist_front_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .action_o      (action_o),
    .turn_o        (turn_o),
    .new_x_o       (new_x_o),
    .new_y_o       (new_y_o),
    .new_heading_o (new_heading_o),
    .depth_o       (depth_o)
  );

endmodule

/* src/gdme_ctrl.sv */
module gdme_ctrl import gdme_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  gdme_status_t status_i,
  output gdme_cmd_t    cmd_o
);

  gdme_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i && !status_i.halted) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK:   state_d = ST_FRONT;
      ST_FRONT:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = status_i.pop_needed ? ST_POP : ST_IDLE;
      ST_POP:    state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.load   = start_i && !status_i.halted;
        cmd_o.report = start_i && status_i.halted;
      end
      ST_MARK:   cmd_o.mark   = 1'b1;
      ST_FRONT:  cmd_o.front  = 1'b1;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_POP:    cmd_o.pop    = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

endmodule

/* src/gdme_datapath.sv */
module gdme_datapath import gdme_pkg::*; #(
  parameter int GRID_SIZE   = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gdme_cmd_t    cmd_i,
  output gdme_status_t status_o,
  input  logic [11:0]  dist_left_i,
  input  logic [11:0]  dist_right_i,
  input  logic [11:0]  dist_front_i,
  input  logic         cfg_valid_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i,
  output logic         done_o,
  output logic [1:0]   action_o,
  output logic [1:0]   turn_o,
  output logic [5:0]   new_x_o,
  output logic [5:0]   new_y_o,
  output logic [1:0]   new_heading_o,
  output logic [12:0]  depth_o
);

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int AW     = 2 * CW;
  localparam int VDEPTH = 1 << AW;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SCW    = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

  // Configuration registers.
  logic [11:0] thr_q;
  logic [5:0]  sx_q, sy_q;
  logic [1:0]  sh_q;

  // Explorer state.
  logic [CW-1:0]  cx_q, cy_q;
  logic [1:0]     hd_q;
  logic [SCW-1:0] cnt_q;
  logic           halted_q, started_q;
  logic [AW-1:0]  clr_cnt_q;

  // Latched readings and visited flags of the side neighbors.
  logic [11:0] dl_q, dr_q, df_q;
  logic        vis_l_q, vis_r_q;

  // Result word.
  action_e action_q;
  turn_e   turn_q;
  logic    done_q;

  // Visited map: one write port, two read ports.
  logic          vmap [VDEPTH];
  logic          vm_we, vm_wd;
  logic [AW-1:0] vm_wa, rd_a, rd_b;
  logic          vis_a_q, vis_b_q;

  // Return stack.
  logic [AW-1:0]  stk [STACK_DEPTH];
  logic [AW-1:0]  pop_q;
  logic [SCW-1:0] cnt_m1;
  logic [SAW-1:0] pop_idx;

  logic [CW-1:0] nb_x [4];
  logic [CW-1:0] nb_y [4];
  logic          nb_ok [4];
  logic [1:0]    dir_l, dir_r, dir_f;

  logic          room, go_l, go_r, go_f, adv, stk_empty;
  logic [1:0]    adv_dir;
  logic [CW-1:0] tx, ty;
  logic          back_ok;
  logic [1:0]    back_dir;

  logic [CW+5:0] sx_ext, sy_ext;
  logic [CW-1:0] sx_clamp, sy_clamp;

  logic [CW+5:0]  ox_ext, oy_ext;
  logic [SCW+12:0] depth_ext;

  // Start position, saturated to the last row or column of the grid.
  assign sx_ext   = {{CW{1'b0}}, sx_q};
  assign sy_ext   = {{CW{1'b0}}, sy_q};
  assign sx_clamp = (sx_ext >= (CW+6)'(GRID_SIZE)) ? LAST : sx_ext[CW-1:0];
  assign sy_clamp = (sy_ext >= (CW+6)'(GRID_SIZE)) ? LAST : sy_ext[CW-1:0];

  // The four neighbors of the current cell with their in-grid flags.
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nb_x[d] = cx_q;
      nb_y[d] = cy_q;
    end
    nb_y[DIR_N]  = cy_q + CW'(1);
    nb_ok[DIR_N] = (cy_q != LAST);
    nb_x[DIR_E]  = cx_q + CW'(1);
    nb_ok[DIR_E] = (cx_q != LAST);
    nb_y[DIR_S]  = cy_q - CW'(1);
    nb_ok[DIR_S] = (cy_q != '0);
    nb_x[DIR_W]  = cx_q - CW'(1);
    nb_ok[DIR_W] = (cx_q != '0);
  end

  assign dir_l = hd_q + 2'd3;
  assign dir_r = hd_q + 2'd1;
  assign dir_f = hd_q;

  // Visited map ports: left and right are read while the current cell is marked,
  // the front neighbor in the cycle after.
  assign rd_a  = cmd_i.mark ? {nb_x[dir_l], nb_y[dir_l]} : {nb_x[dir_f], nb_y[dir_f]};
  assign rd_b  = {nb_x[dir_r], nb_y[dir_r]};
  assign vm_we = cmd_i.clr_en || cmd_i.mark;
  assign vm_wa = cmd_i.clr_en ? clr_cnt_q : {cx_q, cy_q};
  assign vm_wd = cmd_i.mark;

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vmap[vm_wa] <= vm_wd;
    end
    vis_a_q <= vmap[rd_a];
    vis_b_q <= vmap[rd_b];
  end

  // Move choice, valid in the decide cycle when the front flag sits in vis_a_q.
  assign room      = (cnt_q < SCW'(STACK_DEPTH));
  assign go_l      = (dl_q > thr_q) && room && nb_ok[dir_l] && !vis_l_q;
  assign go_r      = (dr_q > thr_q) && room && nb_ok[dir_r] && !vis_r_q;
  assign go_f      = (df_q > thr_q) && room && nb_ok[dir_f] && !vis_a_q;
  assign adv       = go_l || go_r || go_f;
  assign stk_empty = (cnt_q == '0);

  always_comb begin
    priority if (go_l) begin
      adv_dir = dir_l;
    end else if (go_r) begin
      adv_dir = dir_r;
    end else begin
      adv_dir = dir_f;
    end
  end

  // The stack is read at the top entry every cycle; the decide cycle's read
  // feeds the pop cycle.
  assign cnt_m1  = cnt_q - SCW'(1);
  assign pop_idx = cnt_m1[SAW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && adv) begin
      stk[cnt_q[SAW-1:0]] <= {cx_q, cy_q};
    end
    pop_q <= stk[pop_idx];
  end

  assign tx = pop_q[AW-1:CW];
  assign ty = pop_q[CW-1:0];

  // Direction from the current cell toward the popped cell.
  always_comb begin
    back_ok  = 1'b0;
    back_dir = hd_q;
    for (int d = 0; d < 4; d++) begin
      if (!back_ok && nb_ok[d] && (nb_x[d] == tx) && (nb_y[d] == ty)) begin
        back_ok  = 1'b1;
        back_dir = 2'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESH_RESET;
      sx_q      <= START_XY_RESET;
      sy_q      <= START_XY_RESET;
      sh_q      <= START_HEAD_RESET;
      cx_q      <= '0;
      cy_q      <= '0;
      hd_q      <= '0;
      cnt_q     <= '0;
      halted_q  <= 1'b0;
      started_q <= 1'b0;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_THRESHOLD:  thr_q <= cfg_data_i;
          CFG_START_X:    sx_q  <= cfg_data_i[5:0];
          CFG_START_Y:    sy_q  <= cfg_data_i[5:0];
          CFG_START_HEAD: sh_q  <= cfg_data_i[1:0];
          default:        thr_q <= thr_q;
        endcase
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load && !started_q) begin
        cx_q      <= sx_clamp;
        cy_q      <= sy_clamp;
        hd_q      <= sh_q;
        started_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        if (adv) begin
          cnt_q <= cnt_q + SCW'(1);
          cx_q  <= nb_x[adv_dir];
          cy_q  <= nb_y[adv_dir];
          hd_q  <= adv_dir;
        end else if (stk_empty) begin
          halted_q <= 1'b1;
        end else begin
          cnt_q <= cnt_m1;
        end
      end
      if (cmd_i.pop) begin
        cx_q <= tx;
        cy_q <= ty;
        if (back_ok) begin
          hd_q <= back_dir;
        end
      end
      done_q <= cmd_i.report || (cmd_i.decide && (adv || stk_empty)) || cmd_i.pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dl_q <= dist_left_i;
      dr_q <= dist_right_i;
      df_q <= dist_front_i;
    end
    if (cmd_i.front) begin
      vis_l_q <= vis_a_q;
      vis_r_q <= vis_b_q;
    end
    if (cmd_i.report) begin
      action_q <= ACT_HALT;
      turn_q   <= TURN_NONE;
    end
    if (cmd_i.decide) begin
      if (adv) begin
        action_q <= ACT_ADVANCE;
        turn_q   <= turn_e'(adv_dir - hd_q);
      end else begin
        action_q <= ACT_HALT;
        turn_q   <= TURN_NONE;
      end
    end
    if (cmd_i.pop) begin
      action_q <= ACT_BACK;
      turn_q   <= back_ok ? turn_e'(back_dir - hd_q) : TURN_NONE;
    end
  end

  assign status_o.clr_last   = &clr_cnt_q;
  assign status_o.halted     = halted_q;
  assign status_o.pop_needed = !adv && !stk_empty;

  // Position and depth are stable from the update until the next item moves them.
  assign ox_ext    = {6'b0, cx_q};
  assign oy_ext    = {6'b0, cy_q};
  assign depth_ext = {13'b0, cnt_q};

  assign done_o        = done_q;
  assign action_o      = action_q;
  assign turn_o        = turn_q;
  assign new_x_o       = ox_ext[5:0];
  assign new_y_o       = oy_ext[5:0];
  assign new_heading_o = hd_q;
  assign depth_o       = depth_ext[12:0];

endmodule

/* src/gdme_checker.sv */
`include "assert_macros.svh"

module gdme_checker import gdme_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] action_o,
  input logic [1:0] turn_o
);

  // A result is only shown once the block is ready for the next command.
  `GDME_ASSERT_SAME(a_done_not_busy, done_o, !busy, "result shown while busy")

  // A result follows either work in progress or a command taken while halted.
  `GDME_ASSERT_SAME(a_done_has_cause, done_o, $past(busy || start), "result without a command")

  // An advance never reverses the heading.
  `GDME_ASSERT_SAME(a_adv_no_reverse, done_o && (action_o == ACT_ADVANCE),
                    turn_o != TURN_AROUND, "advance with a turn around")

  // Once finished, the block keeps reporting finished.
  `GDME_ASSERT_NEXT(a_halt_sticky, done_o && (action_o == ACT_HALT),
                    !done_o || ((action_o == ACT_HALT) && (turn_o == TURN_NONE)),
                    "result after halt is not a halt")

endmodule

bind grid_dfs_maze_explorer gdme_checker u_gdme_checker (.*);

/* test/grid_dfs_maze_explorer_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the grid depth-first explorer. A scoreboard model of the
// explorer runs alongside the block: every command word that the block accepts is
// applied to the model, whose answer (or a typed row's own) is queued. Each result
// word strobed out is compared, field by field, against the oldest queued answer.
module grid_dfs_maze_explorer_tb;
  import gdme_pkg::*;

  localparam int GRID_SIZE   = 64;
  localparam int STACK_DEPTH = 4096;

  typedef struct packed {
    action_e     action;
    turn_e       turn;
    logic [5:0]  x;
    logic [5:0]  y;
    dir_e        heading;
    logic [12:0] depth;
  } step_res_t;

  typedef struct packed {
    cfg_reg_e    idx;
    logic [11:0] data;
  } cfg_wr_t;

  // One row of the opening sequence. Rows with typed set carry the answer written out
  // by hand; the others are checked against the scoreboard model.
  typedef struct {
    logic [11:0] dl;
    logic [11:0] dr;
    logic [11:0] df;
    bit          typed;
    step_res_t   want;
  } stim_row_t;

  localparam step_res_t NO_RES = '{ACT_HALT, TURN_NONE, 6'd0, 6'd0, DIR_N, 13'd0};

  // Block ports. Every input holds a known value from time zero.
  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [11:0] dist_left_i  = '0;
  logic [11:0] dist_right_i = '0;
  logic [11:0] dist_front_i = '0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = '0;
  logic [11:0] cfg_data_i   = '0;
  logic        done_o;
  logic [1:0]  action_o;
  logic [1:0]  turn_o;
  logic [5:0]  new_x_o;
  logic [5:0]  new_y_o;
  logic [1:0]  new_heading_o;
  logic [12:0] depth_o;

  // Scoreboard model state: registers as written, the explored map, the return path
  // (kept as a queue used like a stack) and the robot pose.
  logic [11:0] thr_reg       = THRESH_RESET;
  logic [5:0]  start_x_reg   = START_XY_RESET;
  logic [5:0]  start_y_reg   = START_XY_RESET;
  logic [1:0]  start_hdg_reg = START_HEAD_RESET;
  bit          visited [GRID_SIZE*GRID_SIZE];
  logic [11:0] trail [$];
  logic [5:0]  cur_x;
  logic [5:0]  cur_y;
  logic [1:0]  cur_hdg;
  bit          halted_flag  = 1'b0;
  bit          started_flag = 1'b0;

  step_res_t expected_steps [$];
  step_res_t head_step;
  cfg_wr_t   cfg_pending [$];
  int        mismatch_count = 0;

  // The opening sequence starts in the top-left corner, (0,63) facing north, with
  // the threshold at 30. It walks along the top edge, where the off-grid neighbors
  // must count as blocked, probes readings equal to and just above the threshold,
  // refuses an open but already explored cell, backtracks with turns around, left
  // and none, and returns to the start cell with an empty path before moving on.
  stim_row_t opening_moves [13] = '{
    '{12'hFFF, 12'd31,  12'hFFF, 1'b1, '{ACT_ADVANCE, TURN_RIGHT,  6'd1, 6'd63, DIR_E, 13'd1}},
    '{12'hFFF, 12'd30,  12'hFFF, 1'b1, '{ACT_ADVANCE, TURN_NONE,   6'd2, 6'd63, DIR_E, 13'd2}},
    '{12'hFFF, 12'hFFF, 12'd0,   1'b1, '{ACT_ADVANCE, TURN_RIGHT,  6'd2, 6'd62, DIR_S, 13'd3}},
    '{12'hFFF, 12'd0,   12'd0,   1'b1, '{ACT_ADVANCE, TURN_LEFT,   6'd3, 6'd62, DIR_E, 13'd4}},
    '{12'd0,   12'd0,   12'd0,   1'b1, '{ACT_BACK,    TURN_AROUND, 6'd2, 6'd62, DIR_W, 13'd3}},
    '{12'd0,   12'hFFF, 12'hFFF, 1'b1, '{ACT_ADVANCE, TURN_NONE,   6'd1, 6'd62, DIR_W, 13'd4}},
    '{12'd0,   12'hFFF, 12'd0,   1'b1, '{ACT_BACK,    TURN_AROUND, 6'd2, 6'd62, DIR_E, 13'd3}},
    '{12'd0,   12'd0,   12'd0,   1'b1, '{ACT_BACK,    TURN_LEFT,   6'd2, 6'd63, DIR_N, 13'd2}},
    '{12'd0,   12'd0,   12'd0,   1'b1, '{ACT_BACK,    TURN_LEFT,   6'd1, 6'd63, DIR_W, 13'd1}},
    '{12'hFFF, 12'hFFF, 12'hFFF, 1'b1, '{ACT_BACK,    TURN_NONE,   6'd0, 6'd63, DIR_W, 13'd0}},
    '{12'hFFF, 12'd0,   12'd0,   1'b1, '{ACT_ADVANCE, TURN_LEFT,   6'd0, 6'd62, DIR_S, 13'd1}},
    '{12'd1,   12'hFFF, 12'd31,  1'b0, NO_RES},
    '{12'hA5A, 12'h5A5, 12'hFFF, 1'b0, NO_RES}
  };

  grid_dfs_maze_explorer #(
    .GRID_SIZE  (GRID_SIZE),
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The pose comes from the start registers at the first command after reset only.
  function automatic void load_start_once();
    if (!started_flag) begin
      cur_x        = start_x_reg;
      cur_y        = start_y_reg;
      cur_hdg      = start_hdg_reg;
      started_flag = 1'b1;
    end
  endfunction

  // Cell next to (x,y) in direction dir; returns 0 when it lies off the grid.
  function automatic bit step_to(input logic [5:0] x, input logic [5:0] y,
                                 input logic [1:0] dir,
                                 output logic [5:0] nx, output logic [5:0] ny);
    int ix;
    int iy;
    ix = x;
    iy = y;
    case (dir_e'(dir))
      DIR_N: iy++;
      DIR_E: ix++;
      DIR_S: iy--;
      default: ix--;
    endcase
    nx = ix[5:0];
    ny = iy[5:0];
    return ix >= 0 && iy >= 0 && ix < GRID_SIZE && iy < GRID_SIZE;
  endfunction

  // Tries left, right, then front. A side qualifies when its reading is above the
  // threshold, the path has room, and the cell is on the grid and still unexplored.
  // Reads the model state but does not change it.
  function automatic bit pick_move(input logic [11:0] dl, input logic [11:0] dr,
                                   input logic [11:0] df,
                                   output logic [1:0] mdir, output logic [5:0] mx,
                                   output logic [5:0] my, output turn_e mturn);
    logic [11:0] rd [3];
    logic [1:0]  dirs [3];
    turn_e       turns [3];
    rd[0]   = dl;
    rd[1]   = dr;
    rd[2]   = df;
    dirs[0] = cur_hdg - 2'd1;
    dirs[1] = cur_hdg + 2'd1;
    dirs[2] = cur_hdg;
    turns   = '{TURN_LEFT, TURN_RIGHT, TURN_NONE};
    mdir    = cur_hdg;
    mx      = cur_x;
    my      = cur_y;
    mturn   = TURN_NONE;
    for (int k = 0; k < 3; k++) begin
      if (rd[k] > thr_reg && trail.size() < STACK_DEPTH &&
          step_to(cur_x, cur_y, dirs[k], mx, my) && !visited[{mx, my}]) begin
        mdir  = dirs[k];
        mturn = turns[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one command word to the model and returns the result word it produces.
  function automatic step_res_t explore_step(input logic [11:0] dl, input logic [11:0] dr,
                                             input logic [11:0] df);
    step_res_t   r;
    logic [1:0]  mdir;
    logic [1:0]  bdir;
    logic [5:0]  nx;
    logic [5:0]  ny;
    logic [11:0] back_cell;
    turn_e       mturn;
    bit          back_found;
    load_start_once();
    r.action = ACT_HALT;
    r.turn   = TURN_NONE;
    if (!halted_flag) begin
      visited[{cur_x, cur_y}] = 1'b1;
      if (pick_move(dl, dr, df, mdir, nx, ny, mturn)) begin
        trail.push_back({cur_x, cur_y});
        cur_x    = nx;
        cur_y    = ny;
        cur_hdg  = mdir;
        r.turn   = mturn;
        r.action = ACT_ADVANCE;
      end else if (trail.size() == 0) begin
        halted_flag = 1'b1;
      end else begin
        // Return to the cell we came from and face the way we move to get there.
        back_cell  = trail.pop_back();
        back_found = 1'b0;
        bdir       = cur_hdg;
        for (int d = 0; d < 4; d++) begin
          if (!back_found && step_to(cur_x, cur_y, 2'(d), nx, ny) &&
              nx == back_cell[11:6] && ny == back_cell[5:0]) begin
            back_found = 1'b1;
            bdir       = 2'(d);
          end
        end
        if (back_found) begin
          r.turn  = turn_e'(bdir - cur_hdg);
          cur_hdg = bdir;
        end
        cur_x    = back_cell[11:6];
        cur_y    = back_cell[5:0];
        r.action = ACT_BACK;
      end
    end
    r.x       = cur_x;
    r.y       = cur_y;
    r.heading = dir_e'(cur_hdg);
    r.depth   = 13'(trail.size());
    return r;
  endfunction

  // True when this reading would end the exploration, which is only wanted at the
  // very end of the run since nothing but a reset brings the block back.
  function automatic bit would_halt(input logic [11:0] dl, input logic [11:0] dr,
                                    input logic [11:0] df);
    logic [1:0] mdir;
    logic [5:0] mx;
    logic [5:0] my;
    turn_e      mturn;
    load_start_once();
    return halted_flag || (trail.size() == 0 && !pick_move(dl, dr, df, mdir, mx, my, mturn));
  endfunction

  // Readings cluster around the threshold so that both open and blocked sides are
  // common, with a share of fully random values so that every bit toggles.
  function automatic logic [11:0] draw_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25 || thr_reg == 12'hFFF) return 12'($urandom_range(0, 4095));
    if (pick < 60) return 12'($urandom_range(thr_reg + 1, 4095));
    if (pick < 90) return 12'($urandom_range(0, thr_reg));
    return (pick < 95) ? thr_reg : thr_reg + 12'd1;
  endfunction

  // Waits until every queued answer has been matched. Always lets at least one edge
  // pass, so a handshake signal lowered in this step is not raised again in it.
  task automatic wait_for_results();
    do @(posedge clk_i); while (expected_steps.size() != 0);
  endtask

  // Writes every queued register word back to back and mirrors each one into the
  // model as it is taken.
  task automatic apply_cfg();
    cfg_wr_t w;
    while (cfg_pending.size() != 0) begin
      w = cfg_pending.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (w.idx)
        CFG_THRESHOLD:  thr_reg       = w.data;
        CFG_START_X:    start_x_reg   = w.data[5:0];
        CFG_START_Y:    start_y_reg   = w.data[5:0];
        CFG_START_HEAD: start_hdg_reg = w.data[1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Presents one command word and holds it until the block takes it. Start stays
  // high into the next command unless a random gap follows.
  task automatic issue_reading(input logic [11:0] dl, input logic [11:0] dr,
                               input logic [11:0] df, input bit typed,
                               input step_res_t typed_res, input int gap_pct);
    step_res_t r;
    start        <= 1'b1;
    dist_left_i  <= dl;
    dist_right_i <= dr;
    dist_front_i <= df;
    do @(posedge clk_i); while (busy);
    r = explore_step(dl, dr, df);
    expected_steps.push_back(typed ? typed_res : r);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic void check_field(input string fname, input logic [12:0] want,
                                      input logic [12:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  // Result monitor. The block shows each result word for exactly one cycle, so it is
  // sampled at the edge that closes the cycle with done_o high.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_steps.size() == 0) begin
        $display("%0t ns: result word with none expected, action %0d x %0d y %0d",
                 $time, action_o, new_x_o, new_y_o);
        mismatch_count++;
      end else begin
        head_step = expected_steps.pop_front();
        check_field("action",  13'(head_step.action),  13'(action_o));
        check_field("turn",    13'(head_step.turn),    13'(turn_o));
        check_field("new_x",   13'(head_step.x),       13'(new_x_o));
        check_field("new_y",   13'(head_step.y),       13'(new_y_o));
        check_field("heading", 13'(head_step.heading), 13'(new_heading_o));
        check_field("depth",   head_step.depth,        depth_o);
      end
    end
  end

  initial begin
    logic [11:0] dl;
    logic [11:0] dr;
    logic [11:0] df;
    logic [11:0] thr;
    int          gap_pct;
    bit          blocked;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The map clearing sweep keeps busy high for a while, but register writes are
    // taken during it. The start registers get both extremes before their final
    // values; only the last ones count, since the pose loads at the first command.
    cfg_pending.push_back('{CFG_THRESHOLD,  12'hFFF});
    cfg_pending.push_back('{CFG_START_X,    12'd63});
    cfg_pending.push_back('{CFG_START_Y,    12'd0});
    cfg_pending.push_back('{CFG_START_HEAD, 12'(DIR_W)});
    cfg_pending.push_back('{CFG_START_X,    12'd0});
    cfg_pending.push_back('{CFG_START_Y,    12'd63});
    cfg_pending.push_back('{CFG_START_HEAD, 12'(DIR_N)});
    cfg_pending.push_back('{CFG_THRESHOLD,  12'd30});
    apply_cfg();

    foreach (opening_moves[i])
      issue_reading(opening_moves[i].dl, opening_moves[i].dr, opening_moves[i].df,
                    opening_moves[i].typed, opening_moves[i].want, 0);
    start <= 1'b0;

    // Random exploration in phases. Each phase sets its own threshold, including
    // both extremes; at the top one no side is ever open and every step backtracks.
    // Odd phases also rewrite a start register, which must change nothing now.
    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      case (p)
        0: thr = 12'd0;
        2: thr = 12'hFFF;
        4: thr = 12'd2048;
        7: thr = 12'd30;
        default: thr = 12'($urandom_range(0, 600));
      endcase
      gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 46 : 12;
      cfg_pending.push_back('{CFG_THRESHOLD, thr});
      if (p % 2 == 1)
        cfg_pending.push_back('{cfg_reg_e'(1 + p % 3), 12'($urandom_range(0, 4095))});
      apply_cfg();

      blocked = 1'b0;
      for (int n = 0; n < (p == 2 ? 20 : 70) && !blocked; n++) begin
        dl = draw_reading();
        dr = draw_reading();
        df = draw_reading();
        // Back at the start cell with nowhere new to go, the block would halt for
        // good. Open every side instead, and if even that halts, end the phase.
        if (would_halt(dl, dr, df)) begin
          dl = 12'hFFF;
          dr = 12'hFFF;
          df = 12'hFFF;
        end
        if (would_halt(dl, dr, df)) begin
          blocked = 1'b1;
        end else begin
          // Now and then let the block run completely dry before the next word.
          if ($urandom_range(0, 39) == 0) begin
            start <= 1'b0;
            wait_for_results();
          end
          issue_reading(dl, dr, df, 1'b0, NO_RES, gap_pct);
        end
      end
      start <= 1'b0;
    end

    // Closed readings unwind the whole path until the explorer halts; a few more
    // words after that must all be answered with the halted pose.
    wait_for_results();
    while (!halted_flag)
      issue_reading(12'd0, 12'd0, 12'd0, 1'b0, NO_RES, 12);
    for (int n = 0; n < 3; n++)
      issue_reading(12'hFFF, 12'hFFF, 12'hFFF, 1'b0, NO_RES, 46);
    start <= 1'b0;

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_steps.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
